[sv/cabn_pkg.sv]
// Shared types and constants for the class-aware box suppression core.
package cabn_pkg;

    localparam int IOU_STAGES = 5;
    localparam logic [15:0] THR_RESET = 16'd29491;

    typedef struct packed {
        logic signed [15:0] box_x;
        logic signed [15:0] box_y;
        logic [15:0]        box_w;
        logic [15:0]        box_h;
        logic [15:0]        score;
        logic [7:0]         class_id;
        logic               last_candidate;
    } cabn_in_t;

    typedef struct packed {
        logic signed [15:0] kept_x;
        logic signed [15:0] kept_y;
        logic [15:0]        kept_w;
        logic [15:0]        kept_h;
        logic [15:0]        kept_score;
        logic [7:0]         kept_class;
        logic               last_kept;
        logic               overflowed;
    } cabn_out_t;

    typedef struct packed {
        logic               vld;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [15:0]        w;
        logic [15:0]        h;
        logic [15:0]        score;
        logic [7:0]         cls;
    } cabn_box_t;

    typedef struct packed {
        logic load_en;
        logic rot_en;
    } cabn_cell_ctl_t;

    typedef enum logic {
        ST_LOAD,
        ST_PROC
    } cabn_state_t;

endpackage

[sv/class_aware_box_nms_core.sv]
// Top level: per-class greedy box suppression over a sorted chain of box cells.
//
//  port group   dir  handshake          word
//  s_*          in   s_valid/s_ready    cabn_in_t   one candidate box
//  m_*          out  m_valid/m_ready    cabn_out_t  one kept box
//  cfg_*        in   cfg_we             16-bit IoU threshold, Q0.16
//
// Loading takes one word per cycle; each box drops into score order in the chain
// at once. The trigger word starts processing, during which s_ready is low.
// Processing rotates the whole ring (MAX_CANDS cells plus the 5-stage overlap
// pipe) once per kept box, and steps past suppressed slots while it seeks the
// next keep. A waiting output word freezes the ring once the next word is due.
// Reset is synchronous and empties the chain; no clearing pass is needed.
module class_aware_box_nms_core #(
    parameter int MAX_CANDS = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  cabn_pkg::cabn_in_t s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output cabn_pkg::cabn_out_t m_data,
    input  logic               cfg_we,
    input  logic [15:0]        cfg_wdata
);

    localparam int NC = MAX_CANDS;
    localparam int R  = MAX_CANDS + cabn_pkg::IOU_STAGES;
    localparam int CW = $clog2(NC + 1);
    localparam int RW = $clog2(R);

    cabn_pkg::cabn_state_t state_reg, state_next;
    logic [15:0]   thr_reg;
    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic          set_ovf_reg, set_ovf_next;
    logic          found_reg, found_next;
    logic          have_act_reg, have_act_next;
    logic [RW-1:0] cnt_reg, cnt_next;
    cabn_pkg::cabn_box_t act_reg, act_next;
    logic          m_valid_reg, m_valid_next;
    cabn_pkg::cabn_out_t m_data_reg, m_data_next;

    cabn_pkg::cabn_box_t c_box [NC];
    logic                c_gt  [NC];
    cabn_pkg::cabn_box_t new_box, iou_in, iou_out;
    cabn_pkg::cabn_cell_ctl_t ctl;

    logic accept, ins, out_free, capture, finish, emit_want, step;

    // broadcast word for insertion
    always_comb begin
        new_box.vld   = 1'b1;
        new_box.x     = s_data.box_x;
        new_box.y     = s_data.box_y;
        new_box.w     = s_data.box_w;
        new_box.h     = s_data.box_h;
        new_box.score = s_data.score;
        new_box.cls   = s_data.class_id;
    end

    assign s_ready  = (state_reg == cabn_pkg::ST_LOAD);
    assign accept   = s_valid && s_ready;
    assign ins      = accept && (count_reg < CW'(NC));
    assign out_free = !m_valid_reg || m_ready;

    // first live box seen at the head while no box is active becomes the next keep
    assign capture   = (state_reg == cabn_pkg::ST_PROC) && !found_reg && c_box[0].vld;
    // a full scan of the ring with nothing live ends the set
    assign finish    = (state_reg == cabn_pkg::ST_PROC) && !found_reg && !c_box[0].vld
                       && (cnt_reg == RW'(R - 1));
    assign emit_want = (capture && have_act_reg) || finish;
    // hold the ring while the output word is still waiting
    assign step      = (state_reg == cabn_pkg::ST_PROC) && !(emit_want && !out_free);

    assign ctl.load_en = ins;
    assign ctl.rot_en  = step;

    always_comb begin
        iou_in = c_box[0];
        if (capture) begin
            iou_in.vld = 1'b0;
        end
    end

    for (genvar i = 0; i < NC; i++) begin : g_cell
        cabn_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctl      (ctl),
            .new_box  (new_box),
            .left_box ((i == 0) ? new_box : c_box[(i == 0) ? 0 : i - 1]),
            .left_gt  ((i == 0) ? 1'b0 : c_gt[(i == 0) ? 0 : i - 1]),
            .right_box((i == NC - 1) ? iou_out : c_box[(i == NC - 1) ? 0 : i + 1]),
            .box      (c_box[i]),
            .gt       (c_gt[i])
        );
    end

    cabn_iou u_iou (
        .aclk   (aclk),
        .aresetn(aresetn),
        .en     (step),
        .thr    (thr_reg),
        .act    (act_reg),
        .in_box (iou_in),
        .out_box(iou_out)
    );

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        set_ovf_next  = set_ovf_reg;
        found_next    = found_reg;
        have_act_next = have_act_reg;
        cnt_next      = cnt_reg;
        act_next      = act_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            cabn_pkg::ST_LOAD: begin
                if (accept) begin
                    if (ins) begin
                        count_next = count_reg + CW'(1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_data.last_candidate) begin
                        // latch the set's flag and open a fresh set
                        set_ovf_next  = ovf_reg || !ins;
                        ovf_next      = 1'b0;
                        count_next    = '0;
                        state_next    = cabn_pkg::ST_PROC;
                        found_next    = 1'b0;
                        have_act_next = 1'b0;
                        cnt_next      = '0;
                    end
                end
            end
            cabn_pkg::ST_PROC: begin
                if (step) begin
                    if (emit_want) begin
                        m_valid_next           = 1'b1;
                        m_data_next.kept_x     = act_reg.x;
                        m_data_next.kept_y     = act_reg.y;
                        m_data_next.kept_w     = act_reg.w;
                        m_data_next.kept_h     = act_reg.h;
                        m_data_next.kept_score = act_reg.score;
                        m_data_next.kept_class = act_reg.cls;
                        m_data_next.last_kept  = finish;
                        m_data_next.overflowed = set_ovf_reg;
                    end
                    if (capture) begin
                        act_next      = c_box[0];
                        have_act_next = 1'b1;
                        found_next    = 1'b1;
                        cnt_next      = RW'(1);
                    end else if (finish) begin
                        state_next    = cabn_pkg::ST_LOAD;
                        have_act_next = 1'b0;
                        cnt_next      = '0;
                    end else if (found_reg && (cnt_reg == RW'(R - 1))) begin
                        // every other box has met the active one: rescan
                        found_next = 1'b0;
                        cnt_next   = '0;
                    end else begin
                        cnt_next = cnt_reg + RW'(1);
                    end
                end
            end
            default: begin
                state_next = cabn_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= cabn_pkg::ST_LOAD;
            thr_reg      <= cabn_pkg::THR_RESET;
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            set_ovf_reg  <= 1'b0;
            found_reg    <= 1'b0;
            have_act_reg <= 1'b0;
            cnt_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            if (cfg_we) begin
                thr_reg <= cfg_wdata;
            end
            count_reg    <= count_next;
            ovf_reg      <= ovf_next;
            set_ovf_reg  <= set_ovf_next;
            found_reg    <= found_next;
            have_act_reg <= have_act_next;
            cnt_reg      <= cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg    <= act_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // checks on the sequencing
    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == cabn_pkg::ST_LOAD) |-> (!found_reg && !have_act_reg))
        else $error("active box left over while loading");

    a_finish_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && finish) |=> (m_valid && m_data.last_kept))
        else $error("set end did not present a last word");

    a_no_overfill: assert property (@(posedge aclk) disable iff (!aresetn)
        ins |-> !c_box[NC - 1].vld)
        else $error("insert into a full chain");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == cabn_pkg::ST_PROC) && !step) |=> $stable(cnt_reg))
        else $error("ring advanced during an output stall");

endmodule

[sv/cabn_cell.sv]
// One cell of the sorted box chain: insert by score while loading, shift while rotating.
module cabn_cell (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  cabn_pkg::cabn_cell_ctl_t ctl,
    input  cabn_pkg::cabn_box_t     new_box,
    input  cabn_pkg::cabn_box_t     left_box,
    input  logic                    left_gt,
    input  cabn_pkg::cabn_box_t     right_box,
    output cabn_pkg::cabn_box_t     box,
    output logic                    gt
);

    cabn_pkg::cabn_box_t box_reg;
    cabn_pkg::cabn_box_t box_next;

    // strict compare keeps equal scores in load order
    assign gt  = !box_reg.vld || (new_box.score > box_reg.score);
    assign box = box_reg;

    always_comb begin
        box_next = box_reg;
        if (ctl.rot_en) begin
            box_next = right_box;
        end else if (ctl.load_en) begin
            if (left_gt) begin
                box_next = left_box;
            end else if (gt) begin
                box_next = new_box;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            box_reg.vld <= 1'b0;
        end else begin
            box_reg <= box_next;
        end
    end

endmodule

[sv/cabn_iou.sv]
// Pipelined overlap test of one box against the kept box; drops the box on excess overlap.
module cabn_iou (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic [15:0]         thr,
    input  cabn_pkg::cabn_box_t act,
    input  cabn_pkg::cabn_box_t in_box,
    output cabn_pkg::cabn_box_t out_box
);

    cabn_pkg::cabn_box_t b1_reg, b2_reg, b3_reg, b4_reg, b5_reg;
    logic        same1_reg, same2_reg, same3_reg, same4_reg;
    logic [15:0] iw1_reg, ih1_reg, aw1_reg, ah1_reg;
    logic [31:0] inter2_reg, aa2_reg, ab2_reg, inter3_reg, inter4_reg;
    logic [33:0] uni3_reg;
    logic [49:0] prod4_reg;

    logic signed [17:0] ax1, ax2, ay1, ay2, bx1, bx2, by1, by2;
    logic signed [17:0] lx, rx, ly, ry, dx, dy;
    logic [15:0] iw, ih;
    logic        hit;
    cabn_pkg::cabn_box_t b5_next;

    always_comb begin
        ax1 = 18'(act.x);
        ay1 = 18'(act.y);
        bx1 = 18'(in_box.x);
        by1 = 18'(in_box.y);
        ax2 = ax1 + $signed({2'b00, act.w});
        ay2 = ay1 + $signed({2'b00, act.h});
        bx2 = bx1 + $signed({2'b00, in_box.w});
        by2 = by1 + $signed({2'b00, in_box.h});
        lx  = (ax1 > bx1) ? ax1 : bx1;
        ly  = (ay1 > by1) ? ay1 : by1;
        rx  = (ax2 < bx2) ? ax2 : bx2;
        ry  = (ay2 < by2) ? ay2 : by2;
        dx  = rx - lx;
        dy  = ry - ly;
        // overlap never exceeds either width, so 16 bits hold it
        iw  = (rx > lx) ? dx[15:0] : 16'd0;
        ih  = (ry > ly) ? dy[15:0] : 16'd0;
        hit = same4_reg && ({2'b00, inter4_reg, 16'd0} > prod4_reg);
        b5_next = b4_reg;
        if (hit) begin
            b5_next.vld = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_reg.vld <= 1'b0;
            b2_reg.vld <= 1'b0;
            b3_reg.vld <= 1'b0;
            b4_reg.vld <= 1'b0;
            b5_reg.vld <= 1'b0;
        end else if (en) begin
            b1_reg     <= in_box;
            same1_reg  <= (in_box.cls == act.cls);
            iw1_reg    <= iw;
            ih1_reg    <= ih;
            aw1_reg    <= act.w;
            ah1_reg    <= act.h;
            b2_reg     <= b1_reg;
            same2_reg  <= same1_reg;
            inter2_reg <= iw1_reg * ih1_reg;
            aa2_reg    <= aw1_reg * ah1_reg;
            ab2_reg    <= b1_reg.w * b1_reg.h;
            b3_reg     <= b2_reg;
            same3_reg  <= same2_reg;
            inter3_reg <= inter2_reg;
            uni3_reg   <= {2'b00, aa2_reg} + {2'b00, ab2_reg} - {2'b00, inter2_reg};
            b4_reg     <= b3_reg;
            same4_reg  <= same3_reg;
            inter4_reg <= inter3_reg;
            prod4_reg  <= thr * uni3_reg;
            b5_reg     <= b5_next;
        end
    end

    assign out_box = b5_reg;

endmodule
